[rtl/core/bnwc_pkg.sv]
// Package for the BLAKE2b nonce work check: stage payload type, hash constants,
// message schedule table and small helpers. No dependencies.
`default_nettype none

package bnwc_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NUM_WORDS  = 16;
    localparam int unsigned NUM_ITEMS  = 4;
    localparam int unsigned NUM_ROUNDS = 12;
    // four cells per half round (one quarter of G each), two half rounds per round
    localparam int unsigned NUM_STAGES = NUM_ROUNDS * 8;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFICULTY = 3'd4;

    localparam logic [63:0] PARAM_WORD0 = 64'h0000_0000_0101_0008;
    localparam logic [63:0] MSG_LEN     = 64'd40;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
          4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
          4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
        '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
          4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
        '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
          4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
        '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
          4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
        '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
          4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
        '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
          4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
        '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
          4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
        '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
          4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
        '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
          4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
    };

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_vec;
    typedef logic [NUM_ITEMS-1:0][WORD_W-1:0] t_items;

    // payload handed from cell to cell
    typedef struct packed {
        t_vec        v;
        logic [63:0] nonce;
    } t_stage;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // working vector at the start of the single final block
    function automatic t_vec init_vec();
        t_vec v;
        for (int i = 0; i < 8; i++) begin
            v[i]     = IV[i];
            v[i + 8] = IV[i];
        end
        v[0]  = IV[0] ^ PARAM_WORD0;
        v[12] = IV[4] ^ MSG_LEN;
        v[14] = ~IV[6];
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bnwc_cell.sv]
// One cell of the compression chain: a quarter of G on all four lanes of a
// column or diagonal half round. Uses bnwc_pkg.
`default_nettype none

module bnwc_cell #(
    parameter int unsigned ROUND = 0,  // 0..11
    parameter int unsigned HALF  = 0,  // 0 column, 1 diagonal
    parameter int unsigned STEP  = 0   // 0..3, quarter of G
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  bnwc_pkg::t_stage      i_data,
    input  bnwc_pkg::t_items      i_item,
    output logic                  o_valid,
    output bnwc_pkg::t_stage      o_data
);

    localparam int unsigned PERM_ROW = ROUND % 10;
    localparam int unsigned ROT_AMT  = (STEP == 0) ? 32 : (STEP == 1) ? 24 :
                                       (STEP == 2) ? 16 : 63;

    logic             r_valid;
    bnwc_pkg::t_stage r_data;
    bnwc_pkg::t_stage n_data;

    function automatic logic [63:0] msg_word(input logic [3:0] idx,
                                             input logic [63:0] nonce,
                                             input bnwc_pkg::t_items item);
        logic [63:0] w;
        case (idx)
            4'd0:    w = nonce;
            4'd1:    w = item[0];
            4'd2:    w = item[1];
            4'd3:    w = item[2];
            4'd4:    w = item[3];
            default: w = '0;  // zero padding
        endcase
        return w;
    endfunction

    always_comb begin
        logic [3:0]  ia, ib, ic, id, sc;
        logic [63:0] sum;
        n_data = i_data;
        for (int g = 0; g < 4; g++) begin
            ia = 4'(g);
            ib = 4'(4  + ((g + HALF)     % 4));
            ic = 4'(8  + ((g + 2 * HALF) % 4));
            id = 4'(12 + ((g + 3 * HALF) % 4));
            sc = 4'(HALF * 8 + 2 * g + STEP / 2);
            if (STEP % 2 == 0) begin
                sum = i_data.v[ia] + i_data.v[ib]
                    + msg_word(bnwc_pkg::SIGMA[PERM_ROW][sc], i_data.nonce, i_item);
                n_data.v[ia] = sum;
                n_data.v[id] = bnwc_pkg::ror64(i_data.v[id] ^ sum, ROT_AMT);
            end else begin
                sum = i_data.v[ic] + i_data.v[id];
                n_data.v[ic] = sum;
                n_data.v[ib] = bnwc_pkg::ror64(i_data.v[ib] ^ sum, ROT_AMT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[rtl/core/bnwc_final.sv]
// Finalization and output register: folds the working vector into the hash
// word, compares it with the threshold and holds the result. Uses bnwc_pkg.
`default_nettype none

module bnwc_final (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  bnwc_pkg::t_stage  i_data,
    input  wire  [63:0]       i_difficulty,
    input  wire               i_ready,
    output logic              o_en,
    output logic              o_valid,
    output logic [63:0]       o_nonce,
    output logic [63:0]       o_hash,
    output logic              o_meets
);

    localparam logic [63:0] H0 = bnwc_pkg::IV[0] ^ bnwc_pkg::PARAM_WORD0;

    logic        r_valid;
    logic [63:0] r_nonce;
    logic [63:0] r_hash;
    logic        r_meets;
    logic [63:0] n_hash;

    assign n_hash = H0 ^ i_data.v[0] ^ i_data.v[8];
    assign o_en   = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_nonce <= i_data.nonce;
            r_hash  <= n_hash;
            r_meets <= (n_hash >= i_difficulty);
        end
    end

    assign o_valid = r_valid;
    assign o_nonce = r_nonce;
    assign o_hash  = r_hash;
    assign o_meets = r_meets;

endmodule

`default_nettype wire

[rtl/core/blake2b_nonce_work_check_unit.sv]
// BLAKE2b nonce work check, top level. Path from request accept to result
// valid: 96 chain cells plus the output register.
// Throughput: one request per cycle; the whole chain advances together, so a
// result held by the downstream side stalls every cell and the input.
// Reset: synchronous, active low; clears all valid bits and the five
// configuration registers to zero. Uses bnwc_pkg, bnwc_cell, bnwc_final.
`default_nettype none

module blake2b_nonce_work_check_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // request stream
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [63:0]  i_s_tdata,   // [63:0] nonce
    // result stream
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [127:0] o_m_tdata,   // [63:0] nonce_echo, [127:64] hash_word
    output logic         o_m_tuser,   // [0] meets_difficulty
    // configuration writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [63:0]  i_cfg_data
);

    localparam int unsigned NS = bnwc_pkg::NUM_STAGES;

    // ---------------------------------------------------------------
    // Configuration registers: item words form message words 1..4.
    // Indexes beyond the list are dropped.
    // ---------------------------------------------------------------
    bnwc_pkg::t_items r_item;
    logic [63:0]      r_difficulty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item       <= '0;
            r_difficulty <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bnwc_pkg::REG_ITEM_0:     r_item[0]    <= i_cfg_data;
                bnwc_pkg::REG_ITEM_1:     r_item[1]    <= i_cfg_data;
                bnwc_pkg::REG_ITEM_2:     r_item[2]    <= i_cfg_data;
                bnwc_pkg::REG_ITEM_3:     r_item[3]    <= i_cfg_data;
                bnwc_pkg::REG_DIFFICULTY: r_difficulty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Chain of cells. Stage k runs round k/8, half (k/4)%2, quarter k%4
    // of G. The initial vector is constant apart from the nonce, which
    // rides along as the message word 0 source.
    // ---------------------------------------------------------------
    logic             w_en;
    logic [NS:0]      w_valid;
    bnwc_pkg::t_stage w_data [NS+1];

    assign o_s_tready     = w_en;
    assign w_valid[0]     = i_s_tvalid;
    assign w_data[0].v    = bnwc_pkg::init_vec();
    assign w_data[0].nonce = i_s_tdata;

    for (genvar k = 0; k < NS; k++) begin : g_cell
        bnwc_cell #(
            .ROUND (k / 8),
            .HALF  ((k / 4) % 2),
            .STEP  (k % 4)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .i_item  (r_item),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Feed-forward, threshold compare and output register. Its enable
    // is the advance signal for the whole chain.
    // ---------------------------------------------------------------
    logic [63:0] w_nonce;
    logic [63:0] w_hash;

    bnwc_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NS]),
        .i_data       (w_data[NS]),
        .i_difficulty (r_difficulty),
        .i_ready      (i_m_tready),
        .o_en         (w_en),
        .o_valid      (o_m_tvalid),
        .o_nonce      (w_nonce),
        .o_hash       (w_hash),
        .o_meets      (o_m_tuser)
    );

    assign o_m_tdata = {w_hash, w_nonce};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a held result must stall the request side
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("request accepted while result stalled");

    // a stalled chain keeps every occupancy bit
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !o_s_tready |=> $stable(w_valid[NS:1]))
        else $error("chain moved during stall");

    // writes past the register list change nothing
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_cfg_valid && o_cfg_ready &&
        (i_cfg_index > bnwc_pkg::REG_DIFFICULTY)
        |=> $stable(r_item) && $stable(r_difficulty))
        else $error("out-of-range config write took effect");

endmodule

`default_nettype wire

[sim/bnwc_checker.sv]
// Checker for the BLAKE2b nonce work check: watches the request, result and
// configuration channels, predicts each result and compares it in order.
// Depends on bnwc_pkg for the register index codes.

module bnwc_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [63:0]  i_s_tdata,   // [63:0] nonce
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [127:0] i_m_tdata,   // [63:0] nonce_echo, [127:64] hash_word
    input  wire          i_m_tuser,   // [0] meets_difficulty
    input  wire          i_cfg_valid,
    input  wire          i_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [63:0]  i_cfg_data,
    output int           o_pending,
    output int           o_fail_count
);

    typedef struct packed {
        logic [63:0] nonce;
        logic [63:0] hash;
        logic        meets;
    } t_work_result;

    localparam logic [63:0] CHAIN_IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    // digest length 8, no key, fanout 1, depth 1
    localparam logic [63:0] PARAM_W0  = 64'h0000_0000_0101_0008;
    localparam logic [63:0] BYTE_CNT  = 64'd40;
    localparam int          N_ROUNDS  = 12;

    localparam logic [3:0] MSG_ORDER [10][16] = '{
        '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
          4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
          4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
        '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
          4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
        '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
          4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
        '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
          4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
        '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
          4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
        '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
          4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
        '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
          4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
        '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
          4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
        '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
          4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
    };

    // word positions of the eight G applications: four columns, four diagonals
    localparam int G_A [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
    localparam int G_B [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
    localparam int G_C [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
    localparam int G_D [8] = '{12, 13, 14, 15, 15, 12, 13, 14};

    logic [63:0]  item_reg [4];
    logic [63:0]  difficulty_reg;
    t_work_result expected_q [$];
    int           fail_total = 0;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // first digest word of the 40-byte message nonce || item
    function automatic logic [63:0] calc_hash(input logic [63:0] nonce,
                                              input logic [63:0] w0, input logic [63:0] w1,
                                              input logic [63:0] w2, input logic [63:0] w3);
        logic [63:0] m [16];
        logic [63:0] v [16];
        int          a, b, c, d, sel;
        for (int i = 0; i < 16; i++) m[i] = '0;
        m[0] = nonce;
        m[1] = w0;
        m[2] = w1;
        m[3] = w2;
        m[4] = w3;
        for (int i = 0; i < 8; i++) begin
            v[i]     = CHAIN_IV[i];
            v[i + 8] = CHAIN_IV[i];
        end
        v[0]  = v[0] ^ PARAM_W0;
        v[12] = v[12] ^ BYTE_CNT;
        v[14] = ~v[14];               // final block
        for (int r = 0; r < N_ROUNDS; r++) begin
            sel = r % 10;
            for (int g = 0; g < 8; g++) begin
                a = G_A[g];
                b = G_B[g];
                c = G_C[g];
                d = G_D[g];
                v[a] = v[a] + v[b] + m[MSG_ORDER[sel][2*g]];
                v[d] = rotr(v[d] ^ v[a], 32);
                v[c] = v[c] + v[d];
                v[b] = rotr(v[b] ^ v[c], 24);
                v[a] = v[a] + v[b] + m[MSG_ORDER[sel][2*g+1]];
                v[d] = rotr(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];
                v[b] = rotr(v[b] ^ v[c], 63);
            end
        end
        return CHAIN_IV[0] ^ PARAM_W0 ^ v[0] ^ v[8];
    endfunction

    task automatic log_fault(input string msg);
        if (fail_total < 10) $display("%s", msg);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_work_result got, want;
        logic [63:0]  hw;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) item_reg[i] <= '0;
            difficulty_reg <= '0;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.nonce = i_m_tdata[63:0];
                got.hash  = i_m_tdata[127:64];
                got.meets = i_m_tuser;
                if (expected_q.size() == 0) begin
                    log_fault($sformatf("unexpected result: nonce %h hash %h flag %b",
                                        got.nonce, got.hash, got.meets));
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want)
                        log_fault($sformatf({"mismatch: nonce exp %h got %h, ",
                                             "hash exp %h got %h, flag exp %b got %b"},
                                            want.nonce, got.nonce, want.hash, got.hash,
                                            want.meets, got.meets));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                hw = calc_hash(i_s_tdata, item_reg[0], item_reg[1], item_reg[2], item_reg[3]);
                want.nonce = i_s_tdata;
                want.hash  = hw;
                want.meets = (hw >= difficulty_reg);
                expected_q.push_back(want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bnwc_pkg::REG_ITEM_0:     item_reg[0]    <= i_cfg_data;
                    bnwc_pkg::REG_ITEM_1:     item_reg[1]    <= i_cfg_data;
                    bnwc_pkg::REG_ITEM_2:     item_reg[2]    <= i_cfg_data;
                    bnwc_pkg::REG_ITEM_3:     item_reg[3]    <= i_cfg_data;
                    bnwc_pkg::REG_DIFFICULTY: difficulty_reg <= i_cfg_data;
                    default: ;  // unused index, write dropped
                endcase
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[sim/testbench.sv]
// Top of the BLAKE2b nonce work check bench: clock, reset, request and
// configuration stimulus, result-side backpressure and the verdict.
// Depends on bnwc_pkg, blake2b_nonce_work_check_unit and bnwc_checker.

module testbench;

    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 150;     // longer than the chain plus the output register
    localparam int HOLD_CYCLES  = 400;     // long enough to fill the whole chain
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_PHASE   = 2;
    localparam int PAUSE_PHASE  = 4;

    // first index past the register map; writes there must be dropped
    localparam logic [2:0] FIRST_UNUSED_IDX = bnwc_pkg::REG_DIFFICULTY + 3'd1;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    logic         stall_en;       // random gaps on both sides
    logic         rx_hold_req;    // set by stimulus, served once by the receiver
    logic         rx_hold_taken;
    int           pending;
    int           fail_count;

    blake2b_nonce_work_check_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bnwc_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall bursts, plus one long hold so the chain
    // backs up all the way to the request port
    initial begin
        m_tready      = 1'b0;
        rx_hold_taken = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold_req && !rx_hold_taken) begin
                rx_hold_taken = 1'b1;
                m_tready      = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // mostly random, with the field extremes and single set bits mixed in
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return rand_word();
        endcase
    endfunction

    // stop offering requests and wait until every result is back
    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // register writes happen only with the chain empty
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        wait_drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_items(input logic [63:0] w0, input logic [63:0] w1,
                               input logic [63:0] w2, input logic [63:0] w3);
        write_reg(bnwc_pkg::REG_ITEM_0, w0);
        write_reg(bnwc_pkg::REG_ITEM_1, w1);
        write_reg(bnwc_pkg::REG_ITEM_2, w2);
        write_reg(bnwc_pkg::REG_ITEM_3, w3);
    endtask

    // offer one request; tvalid stays high so back-to-back requests flow
    task automatic send_nonce(input logic [63:0] n);
        if (stall_en && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = n;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    initial begin
        logic [63:0] items [4];
        logic [63:0] h;
        logic [63:0] probe;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        stall_en    = 1'b0;
        rx_hold_req = 1'b0;
        rst_n       = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // registers at reset: zero item, zero difficulty, so every flag is set
        send_nonce('0);
        send_nonce('1);
        send_nonce(64'd1);
        send_nonce(64'h8000_0000_0000_0000);
        send_nonce(64'h5555_5555_5555_5555);
        send_nonce(64'hAAAA_AAAA_AAAA_AAAA);

        // writes past the register map must leave everything unchanged
        write_reg(FIRST_UNUSED_IDX,        '1);
        write_reg(FIRST_UNUSED_IDX + 3'd1, '1);
        write_reg(FIRST_UNUSED_IDX + 3'd2, '1);
        send_nonce('0);

        // all-ones item and the top difficulty
        write_items('1, '1, '1, '1);
        write_reg(bnwc_pkg::REG_DIFFICULTY, '1);
        send_nonce('0);
        send_nonce('1);

        // compare boundary: difficulty equal to, just above and just below the hash
        items[0] = 64'h0123_4567_89AB_CDEF;
        items[1] = 64'hFEDC_BA98_7654_3210;
        items[2] = 64'h0F0F_0F0F_F0F0_F0F0;
        items[3] = 64'h3C3C_A5A5_5A5A_C3C3;
        probe    = 64'hDEAD_BEEF_0BAD_F00D;
        write_items(items[0], items[1], items[2], items[3]);
        h = chk.calc_hash(probe, items[0], items[1], items[2], items[3]);
        write_reg(bnwc_pkg::REG_DIFFICULTY, h);
        send_nonce(probe);
        write_reg(bnwc_pkg::REG_DIFFICULTY, h + 64'd1);
        send_nonce(probe);
        write_reg(bnwc_pkg::REG_DIFFICULTY, h - 64'd1);
        send_nonce(probe);

        // --- random part: a fresh register setting per phase ---
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            stall_en = (ph != RAND_PHASES - 1);   // last phase runs flat out
            for (int k = 0; k < 4; k++) items[k] = pick_word();
            write_items(items[0], items[1], items[2], items[3]);
            case ($urandom_range(0, 5))
                0:       write_reg(bnwc_pkg::REG_DIFFICULTY, '0);
                1:       write_reg(bnwc_pkg::REG_DIFFICULTY, '1);
                default: write_reg(bnwc_pkg::REG_DIFFICULTY, rand_word());
            endcase
            if ($urandom_range(0, 1) == 0)
                write_reg(FIRST_UNUSED_IDX + 3'($urandom_range(0, 2)), rand_word());
            if (ph == HOLD_PHASE) rx_hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender pause mid-phase until the chain has emptied
                if (ph == PAUSE_PHASE && k == PHASE_ITEMS / 2) wait_drain();
                send_nonce(pick_word());
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[blake2b_nonce_work_check_unit.f]
rtl/core/bnwc_pkg.sv
rtl/core/bnwc_cell.sv
rtl/core/bnwc_final.sv
rtl/core/blake2b_nonce_work_check_unit.sv
sim/bnwc_checker.sv
sim/testbench.sv
